// ----- hdl/lpd_pkg.sv -----
// Shared types and constants for the length-prefixed packet deframer.
package lpd_pkg;

    localparam int unsigned HEADER_BYTES = 6;
    localparam int unsigned COUNT_W      = 3;
    localparam int unsigned LEN_BYTES    = 4;

    localparam logic [COUNT_W-1:0] HDR_PROTO  = COUNT_W'(0);
    localparam logic [COUNT_W-1:0] HDR_OPCODE = COUNT_W'(HEADER_BYTES - 1);

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  protocol;
        logic [7:0]  opcode;
        logic [31:0] length;
        logic [7:0]  data;
        logic        last;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t res;
    } result_beat_t;

endpackage

// ----- hdl/lpd_parser.sv -----
// Header parser and payload counter: state registers and per-byte result logic.
module lpd_parser
    import lpd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         accept,
    input  logic [7:0]   byte_in,
    input  logic [31:0]  max_length,
    output result_beat_t beat
);

    logic               in_payload_reg, in_payload_next;
    logic [COUNT_W-1:0] header_count_reg, header_count_next;
    logic [7:0]         proto_reg, proto_next;
    logic [31:0]        length_reg, length_next;
    logic [7:0]         opcode_reg, opcode_next;
    logic [31:0]        bytes_left_reg, bytes_left_next;

    always_comb
    begin
        in_payload_next   = in_payload_reg;
        header_count_next = header_count_reg;
        proto_next        = proto_reg;
        length_next       = length_reg;
        opcode_next       = opcode_reg;
        bytes_left_next   = bytes_left_reg;
        beat.valid        = 1'b0;
        beat.res.kind     = KIND_HEADER;
        beat.res.data     = 8'd0;
        beat.res.last     = 1'b0;

        if (in_payload_reg)
        begin
            if (bytes_left_reg != 32'd0)
                bytes_left_next = bytes_left_reg - 32'd1;
            beat.valid    = 1'b1;
            beat.res.kind = KIND_PAYLOAD;
            beat.res.data = byte_in;
            beat.res.last = (bytes_left_reg <= 32'd1);
            if (bytes_left_reg <= 32'd1)
                in_payload_next = 1'b0;
        end
        else if (header_count_reg == HDR_OPCODE)
        begin
            opcode_next       = byte_in;
            header_count_next = HDR_PROTO;
            beat.valid        = 1'b1;
            beat.res.last     = 1'b1;
            if (length_reg == 32'd0 || length_reg > max_length)
            begin
                beat.res.kind = KIND_ERROR;
            end
            else
            begin
                bytes_left_next = length_reg - 32'd1;
                if (length_reg != 32'd1)
                begin
                    beat.res.last   = 1'b0;
                    in_payload_next = 1'b1;
                end
            end
        end
        else if (header_count_reg == HDR_PROTO || header_count_reg > HDR_OPCODE)
        begin
            proto_next        = byte_in;
            header_count_next = HDR_PROTO + COUNT_W'(1);
        end
        else
        begin
            for (int i = 0; i < LEN_BYTES; i++)
            begin
                if (header_count_reg == COUNT_W'(i + 1))
                    length_next[8*i +: 8] = byte_in;
            end
            header_count_next = header_count_reg + COUNT_W'(1);
        end

        beat.res.protocol = proto_next;
        beat.res.opcode   = opcode_next;
        beat.res.length   = length_next;
        beat.valid        = beat.valid & accept;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_payload_reg   <= 1'b0;
            header_count_reg <= HDR_PROTO;
            proto_reg        <= 8'd0;
            length_reg       <= 32'd0;
            opcode_reg       <= 8'd0;
            bytes_left_reg   <= 32'd0;
        end
        else if (accept)
        begin
            in_payload_reg   <= in_payload_next;
            header_count_reg <= header_count_next;
            proto_reg        <= proto_next;
            length_reg       <= length_next;
            opcode_reg       <= opcode_next;
            bytes_left_reg   <= bytes_left_next;
        end
    end

endmodule

// ----- hdl/lpd_out_buf.sv -----
// Two-entry result register with skid stage between parser and receiver.
module lpd_out_buf
    import lpd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  result_beat_t beat,
    input  logic         result_stall,
    output logic         full,
    output logic         result_valid,
    output result_t      result
);

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_reg;
    result_t skid_reg;
    logic    pop;

    assign pop          = main_valid_reg && !result_stall;
    assign full         = skid_valid_reg;
    assign result_valid = main_valid_reg;
    assign result       = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (beat.valid)
        begin
            if (main_valid_reg && !pop)
                skid_valid_reg <= 1'b1;
            else
                main_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                main_reg <= skid_reg;
        end
        else if (beat.valid)
        begin
            if (main_valid_reg && !pop)
                skid_reg <= beat.res;
            else
                main_reg <= beat.res;
        end
    end

endmodule

// ----- hdl/length_prefixed_packet_deframer.sv -----
// Top level of the length-prefixed packet deframer.
//
// Input: one stream byte per beat on byte_in, byte_valid / byte_stall.
// Each packet is a 6-byte header (protocol, 32-bit little-endian length,
// opcode) followed by length - 1 payload bytes. The sixth header byte gives
// a header result (kind 0, last set when no payload follows); each payload
// byte gives a kind 1 result, the final one with last set. A length of zero
// or above max_length gives a kind 2 result with last set and the block
// hunts for the next header.
// Output: result_valid / result_stall with kind, protocol, opcode, length,
// data and last. Each result is registered before it reaches the output.
// Throughput is one byte per cycle; byte_stall rises only when both the
// result register and the skid register hold beats the receiver has not
// taken, and drops at the edge where the receiver takes one.
// Configuration: max_length is written on max_length_valid (ready is always
// high); write it only while no packet is in flight.
// Reset clears the parser to header hunting, empties the result stage and
// sets max_length to all ones.
module length_prefixed_packet_deframer
    import lpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        max_length_valid,
    output logic        max_length_ready,
    input  logic [31:0] max_length,

    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  byte_in,

    output logic        result_valid,
    input  logic        result_stall,
    output logic [1:0]  kind,
    output logic [7:0]  protocol,
    output logic [7:0]  opcode,
    output logic [31:0] length,
    output logic [7:0]  data,
    output logic        last
);

    logic [31:0]  max_length_reg;
    logic         accept;
    logic         full;
    result_beat_t beat;
    result_t      result;

    assign max_length_ready = 1'b1;
    assign byte_stall       = full;
    assign accept           = byte_valid && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_length_reg <= 32'hFFFF_FFFF;
        else if (max_length_valid)
            max_length_reg <= max_length;
    end

    lpd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .byte_in    (byte_in),
        .max_length (max_length_reg),
        .beat       (beat)
    );

    lpd_out_buf u_out_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .beat         (beat),
        .result_stall (result_stall),
        .full         (full),
        .result_valid (result_valid),
        .result       (result)
    );

    assign kind     = result.kind;
    assign protocol = result.protocol;
    assign opcode   = result.opcode;
    assign length   = result.length;
    assign data     = result.data;
    assign last     = result.last;

endmodule
